@@ sv/dps_pkg.sv @@
// Shared types and constants for the dynamic priority scheduler.
// No dependencies; imported by dps_cell, dynamic_priority_scheduler_top and the test files.
`default_nettype none

package dps_pkg;

  localparam int NAME_W = 8;
  localparam int PRI_W  = 16;
  localparam int RUN_W  = 16;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 6;

  // item kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RAN   = 2'd2;
  localparam logic [STAT_W-1:0] ST_IDLE  = 2'd3;

  localparam logic signed [PRI_W-1:0] PRI_MIN = 16'sh8000;

  // best candidate so far, handed from cell to cell during a scan
  typedef struct packed {
    logic                    found;
    logic signed [PRI_W-1:0] pri;
    logic [RUN_W-1:0]        rem;
    logic [NAME_W-1:0]       name;
  } tok_t;

  // entry contents written into one cell
  typedef struct packed {
    logic [NAME_W-1:0]       name;
    logic signed [PRI_W-1:0] pri;
    logic [RUN_W-1:0]        rem;
    logic                    done;
  } wr_t;

endpackage : dps_pkg

`default_nettype wire

@@ sv/dynamic_priority_scheduler_top.sv @@
// Top level of the dynamic priority scheduler: control, fill count and the row of cells.
// Depends on dps_pkg and dps_cell.
//
// The block keeps up to MAX_ENTRIES process entries, one per cell in a chain. An add beat
// is stored and its result registered at the edge that accepts it. A tick beat walks a
// best-candidate token down the chain, one cell per cycle, in the scan state; the serve
// state then updates the winning cell and loads the result. One item
// is worked on at a time; the result sits in an output register, so the next item is taken
// as soon as the block is idle and that register is empty or being emptied. Entry contents
// need no clearing after reset; the fill count is reset to zero.
`default_nettype none

module dynamic_priority_scheduler_top
  import dps_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    kind_i,
  input  wire logic [NAME_W-1:0]       process_id_i,
  input  wire logic signed [PRI_W-1:0] start_priority_i,
  input  wire logic [RUN_W-1:0]        run_time_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [STAT_W-1:0]            status_o,
  output logic [SLOT_W-1:0]            slot_o,
  output logic [NAME_W-1:0]            served_id_o,
  output logic signed [PRI_W-1:0]      priority_after_o,
  output logic [RUN_W-1:0]             runtime_after_o,
  output logic                         finished_o
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SERVE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] scan_q;

  logic                    out_valid_q;
  logic [STAT_W-1:0]       status_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [NAME_W-1:0]       id_q;
  logic signed [PRI_W-1:0] pri_q;
  logic [RUN_W-1:0]        rem_q;
  logic                    fin_q;

  tok_t             tok   [MAX_ENTRIES+1];
  logic [IDX_W-1:0] idx   [MAX_ENTRIES+1];

  logic             out_free, in_acc, full, res_load;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  wr_t              wr;

  tok_t                    best;
  logic signed [PRI_W-1:0] pri_new;
  logic [RUN_W-1:0]        rem_new;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(MAX_ENTRIES));
  // a result is loaded by an add beat or at the end of a tick
  assign res_load   = (state_q == S_SERVE) ||
                      ((state_q == S_IDLE) && in_acc && (kind_i == KIND_ADD));

  // the chain always starts from an empty candidate
  assign tok[0] = '0;
  assign idx[0] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    dps_cell #(
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W),
      .CELL_IDX(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .tok_i   (tok[g]),
      .idx_i   (idx[g]),
      .tok_o   (tok[g+1]),
      .idx_o   (idx[g+1]),
      .wr_en_i (wr_en),
      .wr_idx_i(wr_idx),
      .wr_i    (wr)
    );
  end

  assign best    = tok[MAX_ENTRIES];
  assign pri_new = (best.pri == PRI_MIN) ? best.pri : best.pri - 16'sd1;
  assign rem_new = (best.rem != '0) ? best.rem - 16'd1 : best.rem;

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = idx[MAX_ENTRIES];
    wr     = '{name: best.name, pri: pri_new, rem: rem_new, done: (rem_new == '0)};
    if (state_q == S_IDLE) begin
      wr_en  = in_acc && (kind_i == KIND_ADD) && !full;
      wr_idx = count_q[IDX_W-1:0];
      wr     = '{name: process_id_i, pri: start_priority_i, rem: run_time_i,
                 done: (run_time_i == '0)};
    end else if (state_q == S_SERVE) begin
      wr_en = best.found;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_IDLE;
      slot_q      <= '0;
      id_q        <= '0;
      pri_q       <= '0;
      rem_q       <= '0;
      fin_q       <= 1'b0;
    end else begin
      // load a new result beat, or drop the current one once taken
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (kind_i == KIND_TICK) begin
              scan_q  <= '0;
              state_q <= S_SCAN;
            end else begin
              fin_q       <= 1'b0;
              if (full) begin
                status_q <= ST_FULL;
                slot_q   <= '0;
                id_q     <= '0;
                pri_q    <= '0;
                rem_q    <= '0;
              end else begin
                status_q <= ST_ADDED;
                slot_q   <= SLOT_W'(count_q);
                id_q     <= process_id_i;
                pri_q    <= start_priority_i;
                rem_q    <= run_time_i;
                count_q  <= count_q + CNT_W'(1);
              end
            end
          end
        end
        S_SCAN: begin
          // wait for the token to leave the last cell
          if (scan_q == IDX_W'(MAX_ENTRIES - 1)) begin
            state_q <= S_SERVE;
          end else begin
            scan_q <= scan_q + IDX_W'(1);
          end
        end
        S_SERVE: begin
          state_q     <= S_IDLE;
          if (best.found) begin
            status_q <= ST_RAN;
            slot_q   <= SLOT_W'(idx[MAX_ENTRIES]);
            id_q     <= best.name;
            pri_q    <= pri_new;
            rem_q    <= rem_new;
            fin_q    <= (rem_new == '0);
          end else begin
            status_q <= ST_IDLE;
            slot_q   <= '0;
            id_q     <= '0;
            pri_q    <= '0;
            rem_q    <= '0;
            fin_q    <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_o           = slot_q;
  assign served_id_o      = id_q;
  assign priority_after_o = pri_q;
  assign runtime_after_o  = rem_q;
  assign finished_o       = fin_q;

endmodule : dynamic_priority_scheduler_top

`default_nettype wire

@@ sv/dps_cell.sv @@
// One table cell: holds a single process entry and the compare stage of the scan chain.
// Depends on dps_pkg for tok_t and wr_t.
`default_nettype none

module dps_cell
  import dps_pkg::*;
#(
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire tok_t             tok_i,
  input  wire logic [IDX_W-1:0] idx_i,
  output tok_t                  tok_o,
  output logic [IDX_W-1:0]      idx_o,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire wr_t              wr_i
);

  logic [NAME_W-1:0]       name_q;
  logic signed [PRI_W-1:0] pri_q;
  logic [RUN_W-1:0]        rem_q;
  logic                    done_q;

  tok_t             tok_q, tok_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             ready, take;

  // entries at or beyond the fill count are never read
  assign ready = (CNT_W'(CELL_IDX) < count_i) && !done_q;
  // strict greater-than keeps the lower index on a tie
  assign take  = ready && (!tok_i.found || ($signed(pri_q) > $signed(tok_i.pri)));

  always_comb begin
    tok_d = tok_i;
    idx_d = idx_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.pri   = pri_q;
      tok_d.rem   = rem_q;
      tok_d.name  = name_q;
      idx_d       = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      idx_q <= '0;
    end else begin
      tok_q <= tok_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == IDX_W'(CELL_IDX))) begin
      name_q <= wr_i.name;
      pri_q  <= wr_i.pri;
      rem_q  <= wr_i.rem;
      done_q <= wr_i.done;
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule : dps_cell

`default_nettype wire

@@ test/dps_schedule_checker.sv @@
// Scoreboard for the dynamic priority scheduler: watches both channels,
// keeps its own copy of the process table and compares every result beat.
// Depends on dps_pkg.
`default_nettype none

module dps_schedule_checker
  import dps_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_stall_i,
  input  wire logic                    kind_i,
  input  wire logic [NAME_W-1:0]       process_id_i,
  input  wire logic signed [PRI_W-1:0] start_priority_i,
  input  wire logic [RUN_W-1:0]        run_time_i,
  input  wire logic                    out_valid_i,
  input  wire logic                    out_stall_i,
  input  wire logic [STAT_W-1:0]       status_i,
  input  wire logic [SLOT_W-1:0]       slot_i,
  input  wire logic [NAME_W-1:0]       served_id_i,
  input  wire logic signed [PRI_W-1:0] priority_after_i,
  input  wire logic [RUN_W-1:0]        runtime_after_i,
  input  wire logic                    finished_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           added_o,
  output int                           rejected_o,
  output int                           served_o,
  output int                           idle_o,
  output int                           completed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [SLOT_W-1:0]       slot;
    logic [NAME_W-1:0]       id;
    logic signed [PRI_W-1:0] pri;
    logic [RUN_W-1:0]        rem;
    logic                    fin;
  } sched_result_t;

  logic [NAME_W-1:0]       name_tab [MAX_ENTRIES];
  logic signed [PRI_W-1:0] pri_tab  [MAX_ENTRIES];
  logic [RUN_W-1:0]        rem_tab  [MAX_ENTRIES];
  logic                    done_tab [MAX_ENTRIES];
  int                      fill;
  sched_result_t           awaited_q [$];

  // Apply one input beat to the table and return the result it should give.
  function automatic sched_result_t schedule_step(logic kind, logic [NAME_W-1:0] id,
                                                  logic signed [PRI_W-1:0] pri,
                                                  logic [RUN_W-1:0] rt);
    sched_result_t           r;
    logic                    found;
    int                      best;
    int                      i;
    logic signed [PRI_W-1:0] best_pri;
    r        = '0;
    found    = 1'b0;
    best     = 0;
    best_pri = '0;
    if (kind == KIND_ADD) begin
      if (fill >= MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        name_tab[fill] = id;
        pri_tab[fill]  = pri;
        rem_tab[fill]  = rt;
        done_tab[fill] = (rt == '0);
        r.status = ST_ADDED;
        r.slot   = fill[SLOT_W-1:0];
        r.id     = id;
        r.pri    = pri;
        r.rem    = rt;
        fill++;
      end
    end else begin
      // strict greater-than keeps the lowest index on a tie
      for (i = 0; i < fill; i++) begin
        if (!done_tab[i] && (!found || pri_tab[i] > best_pri)) begin
          found    = 1'b1;
          best     = i;
          best_pri = pri_tab[i];
        end
      end
      if (!found) begin
        r.status = ST_IDLE;
      end else begin
        if (pri_tab[best] != PRI_MIN) pri_tab[best] = pri_tab[best] - 16'sd1;
        if (rem_tab[best] != '0) rem_tab[best] = rem_tab[best] - 16'd1;
        if (rem_tab[best] == '0) done_tab[best] = 1'b1;
        r.status = ST_RAN;
        r.slot   = best[SLOT_W-1:0];
        r.id     = name_tab[best];
        r.pri    = pri_tab[best];
        r.rem    = rem_tab[best];
        r.fin    = (rem_tab[best] == '0);
      end
    end
    return r;
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sched_result_t want;
    if (!rst_ni) begin
      fill = 0;
      awaited_q.delete();
      pending_o <= 0;
    end else begin
      // results are registered, so a result beat never belongs to this edge's input beat
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d slot %0d id %0d",
                   $time, status_i, slot_i, served_id_i);
          fail_count_o++;
        end else begin
          want = awaited_q.pop_front();
          check_field("status", longint'(want.status), longint'(status_i));
          check_field("slot", longint'(want.slot), longint'(slot_i));
          check_field("served_id", longint'(want.id), longint'(served_id_i));
          check_field("priority_after", longint'(want.pri), longint'(priority_after_i));
          check_field("runtime_after", longint'(want.rem), longint'(runtime_after_i));
          check_field("finished", longint'(want.fin), longint'(finished_i));
          case (want.status)
            ST_ADDED: added_o++;
            ST_FULL:  rejected_o++;
            ST_RAN:   served_o++;
            default:  idle_o++;
          endcase
          if (want.fin) completed_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_q.push_back(schedule_step(kind_i, process_id_i, start_priority_i, run_time_i));
      end
      pending_o <= awaited_q.size();
    end
  end

endmodule : dps_schedule_checker

`default_nettype wire

@@ test/tb_dynamic_priority_scheduler_top.sv @@
// Testbench top for the dynamic priority scheduler: clock, reset, stimulus and verdict.
// Depends on dps_pkg, dynamic_priority_scheduler_top and dps_schedule_checker.
`default_nettype none

module tb_dynamic_priority_scheduler_top;
  import dps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES     = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 600;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    kind           = KIND_ADD;
  logic [NAME_W-1:0]       process_id     = '0;
  logic signed [PRI_W-1:0] start_priority = '0;
  logic [RUN_W-1:0]        run_time       = '0;
  logic                    out_stall      = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic [STAT_W-1:0]       status;
  logic [SLOT_W-1:0]       slot;
  logic [NAME_W-1:0]       served_id;
  logic signed [PRI_W-1:0] priority_after;
  logic [RUN_W-1:0]        runtime_after;
  logic                    finished;

  int send_pct = 8;
  int recv_pct = 47;
  int hold_req = 0;
  int fail_count, pending, n_added, n_rejected, n_served, n_idle, n_completed;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dynamic_priority_scheduler_top #(
    .MAX_ENTRIES(ENTRIES)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .process_id_i    (process_id),
    .start_priority_i(start_priority),
    .run_time_i      (run_time),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .slot_o          (slot),
    .served_id_o     (served_id),
    .priority_after_o(priority_after),
    .runtime_after_o (runtime_after),
    .finished_o      (finished)
  );

  dps_schedule_checker #(
    .MAX_ENTRIES(ENTRIES)
  ) sched_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .kind_i          (kind),
    .process_id_i    (process_id),
    .start_priority_i(start_priority),
    .run_time_i      (run_time),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .slot_i          (slot),
    .served_id_i     (served_id),
    .priority_after_i(priority_after),
    .runtime_after_i (runtime_after),
    .finished_i      (finished),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .added_o         (n_added),
    .rejected_o      (n_rejected),
    .served_o        (n_served),
    .idle_o          (n_idle),
    .completed_o     (n_completed)
  );

  // Offer one beat, with an optional random gap first; return at the accepting edge.
  task automatic offer(logic k, logic [NAME_W-1:0] id, logic signed [PRI_W-1:0] pri,
                       logic [RUN_W-1:0] rt);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    process_id     <= id;
    start_priority <= pri;
    run_time       <= rt;
    do @(posedge clk); while (in_stall);
  endtask

  // tick payload is ignored by the block, so fill it with noise
  task automatic tick();
    offer(KIND_TICK, NAME_W'($urandom), PRI_W'($urandom), RUN_W'($urandom));
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  initial begin : stimulus
    logic [RUN_W-1:0]        rt;
    logic signed [PRI_W-1:0] pri;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    tick();                                 // empty table: idle
    offer(KIND_ADD, 8'hFF, 16'sh7FFF, 16'd1);
    offer(KIND_ADD, 8'h00, PRI_MIN, 16'd2);
    offer(KIND_ADD, 8'h5A, 16'sd0, 16'd0);  // stored finished, never served
    offer(KIND_ADD, 8'hA5, 16'sd0, 16'd3);
    offer(KIND_ADD, 8'h3C, 16'sd0, 16'd3);  // ties with the entry before it
    repeat (7) tick();                      // top entry, then the tied pair in turn
    repeat (2) tick();                      // entry held at the priority floor
    tick();                                 // nothing ready: idle

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_pct = 8;  recv_pct <= 47; end
        1: begin send_pct = 47; recv_pct <= 8;  end
        default: begin send_pct = 0; recv_pct <= 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == PHASE_ITEMS / 2) hold_req <= hold_req + 1;
        if ($urandom_range(99) < 8) begin
          case ($urandom_range(19))
            0:       rt = '0;
            1:       rt = RUN_W'($urandom);
            default: rt = RUN_W'($urandom_range(40, 1));
          endcase
          // keep long jobs near the floor so they do not starve the rest
          if (rt > 40) begin
            pri = PRI_W'(PRI_MIN + $urandom_range(2));
          end else begin
            case ($urandom_range(9))
              0:       pri = PRI_MIN;
              1:       pri = 16'sh7FFF;
              2, 3:    pri = PRI_W'($urandom);
              default: pri = PRI_W'($urandom_range(6) - 3);
            endcase
          end
          offer(KIND_ADD, NAME_W'($urandom), pri, rt);
        end else begin
          tick();
        end
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (ENTRIES + 4) @(posedge clk);
    $display("covered %0d adds (%0d rejected on a full table), %0d ticks served",
             n_added, n_rejected, n_served);
    $display("with %0d completions and %0d idle ticks", n_completed, n_idle);
    if (fail_count == 0) begin
      $display("tb_dynamic_priority_scheduler_top passed");
    end else begin
      $display("tb_dynamic_priority_scheduler_top failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb_dynamic_priority_scheduler_top failed");
    $finish;
  end

endmodule : tb_dynamic_priority_scheduler_top

`default_nettype wire
